/* rtl/caio_pkg.sv */
`default_nettype none
package caio_pkg;

    localparam int PORT_COUNT_DEF = 32;
    localparam int ADDR_W         = 5;

    // port numbers with a write side effect
    localparam logic [ADDR_W-1:0] PORT_STATUS    = 5'h00;
    localparam logic [ADDR_W-1:0] PORT_MEMCTL    = 5'h01;
    localparam logic [ADDR_W-1:0] PORT_WRAP      = 5'h04;
    localparam logic [ADDR_W-1:0] PORT_STOP      = 5'h05;
    localparam logic [ADDR_W-1:0] PORT_LINK_CTL  = 5'h0c;
    localparam logic [ADDR_W-1:0] PORT_RAW_WIRE  = 5'h0e;
    localparam logic [ADDR_W-1:0] PORT_LINK_DATA = 5'h0f;
    localparam logic [ADDR_W-1:0] PORT_LCD_HI    = 5'h10;
    localparam logic [ADDR_W-1:0] PORT_LCD_LO    = 5'h11;
    localparam logic [ADDR_W-1:0] PORT_TIMER     = 5'h17;
    localparam logic [ADDR_W-1:0] PORT_LCD_OFF   = 5'h1c;
    localparam logic [ADDR_W-1:0] PORT_CONTRAST  = 5'h1d;

    localparam logic [7:0] ID_EVEN    = 8'h14;
    localparam logic [7:0] ID_ODD     = 8'h01;
    localparam logic [7:0] ID_PORT21  = 8'h1b;
    localparam logic [7:0] LINK_AVAIL = 8'h60;
    localparam logic [7:0] LINK_IDLE  = 8'h40;
    localparam logic [7:0] RAW_BASE   = 8'h50;
    localparam logic [7:0] ONKEY_BASE = 8'h14;
    localparam logic [7:0] STATUS_B2  = 8'h04;

    typedef enum logic [1:0] {
        SCR_NONE = 2'd0,
        SCR_ON   = 2'd1,
        SCR_OFF  = 2'd2
    } caio_scr_t;

    typedef enum logic [3:0] {
        RD_MEM,
        RD_STATUS,
        RD_MEMCTL,
        RD_ID_EVEN,
        RD_ID_ODD,
        RD_ID_21,
        RD_LINK_STAT,
        RD_RAW,
        RD_LINK_RX,
        RD_TIMER,
        RD_ONKEY,
        RD_KEYS
    } caio_rd_t;

    // read function of each port, indexed by port number
    localparam caio_rd_t READ_MAP [32] = '{
        RD_STATUS,  RD_MEMCTL,    RD_ID_EVEN, RD_ID_ODD,
        RD_ID_EVEN, RD_ID_ODD,    RD_ID_EVEN, RD_ID_ODD,
        RD_ID_EVEN, RD_ID_ODD,    RD_ID_EVEN, RD_ID_ODD,
        RD_MEM,     RD_LINK_STAT, RD_RAW,     RD_LINK_RX,
        RD_ID_EVEN, RD_ID_ODD,    RD_ID_EVEN, RD_ID_ODD,
        RD_ID_EVEN, RD_ID_21,     RD_ID_EVEN, RD_TIMER,
        RD_MEM,     RD_MEM,       RD_ONKEY,   RD_KEYS,
        RD_ID_EVEN, RD_ID_ODD,    RD_ID_EVEN, RD_ID_ODD
    };

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_data;
        logic [7:0]        link_rx_byte;
        logic              link_byte_available;
        logic [7:0]        timer_count;
        logic              on_key_pressed;
        logic [7:0]        key_row_mask;
        logic              red_wire_level;
        logic              white_wire_level;
    } caio_item_t;

    // everything of a result except the stored byte
    typedef struct packed {
        logic        sel_mem;
        logic [7:0]  data_imm;
        logic        link_tx_valid;
        logic        link_rx_taken;
        logic        stop_request;
        logic [4:0]  contrast_level;
        caio_scr_t   screen_event;
        logic        wire_drive_valid;
        logic        red_wire_out;
        logic        white_wire_out;
        logic [18:0] lcd_base_address;
        logic        ram_window_256k;
        logic        memory_protect;
    } caio_meta_t;

endpackage
`default_nettype wire

/* rtl/caio_port_ram.sv */
`default_nettype none
module caio_port_ram #(
    parameter int PORT_COUNT = caio_pkg::PORT_COUNT_DEF,
    parameter int AW         = $clog2(PORT_COUNT)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic [7:0]         rdata
);

    logic [7:0]            mem [PORT_COUNT];
    logic [PORT_COUNT-1:0] valid_reg;
    logic [7:0]            rd_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[addr] <= wdata;
        end
        if (en) begin
            rd_reg <= mem[addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else if (en) begin
            rd_valid_reg <= valid_reg[addr];
            if (we) begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : 8'h00;

endmodule
`default_nettype wire

/* rtl/caio_ctrl.sv */
`default_nettype none
module caio_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_bit,
    input  wire logic                accept,
    input  wire caio_pkg::caio_item_t item,
    output caio_pkg::caio_meta_t     meta
);

    logic        model_is_92_reg;
    logic [4:0]  contrast_reg, contrast_next;
    logic        status_bit7_reg, status_bit7_next;
    logic        status_bit2_reg, status_bit2_next;
    logic        ram_128k_reg, ram_128k_next;
    logic        protect_reg, protect_next;
    logic        wrap_reg, wrap_next;
    logic        window_reg, window_next;
    logic        raw_reg, raw_next;
    logic [15:0] lcd_base_reg, lcd_base_next;
    logic        lcd_off_reg, lcd_off_next;
    logic [7:0]  reload_reg, reload_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_is_92_reg <= 1'b0;
        end else if (cfg_we) begin
            model_is_92_reg <= cfg_bit;
        end
    end

    always_comb begin
        logic [7:0] d;
        d = item.write_data;

        contrast_next    = contrast_reg;
        status_bit7_next = status_bit7_reg;
        status_bit2_next = status_bit2_reg;
        ram_128k_next    = ram_128k_reg;
        protect_next     = protect_reg;
        wrap_next        = wrap_reg;
        window_next      = window_reg;
        raw_next         = raw_reg;
        lcd_base_next    = lcd_base_reg;
        lcd_off_next     = lcd_off_reg;
        reload_next      = reload_reg;

        meta = '0;
        meta.screen_event = caio_pkg::SCR_NONE;

        if (item.command) begin
            unique case (item.address)
                caio_pkg::PORT_STATUS: begin
                    // the contrast bit moves from d[5] on the 92 and on other models alike
                    contrast_next    = model_is_92_reg ? {contrast_reg[4:1], d[5]}
                                                       : {contrast_reg[4:1], d[5]};
                    status_bit7_next = d[7];
                    status_bit2_next = d[2];
                end
                caio_pkg::PORT_MEMCTL: begin
                    ram_128k_next = d[0];
                    protect_next  = d[2];
                    window_next   = !wrap_reg && !d[0];
                end
                caio_pkg::PORT_WRAP: begin
                    wrap_next = d[3];
                end
                caio_pkg::PORT_STOP: begin
                    meta.stop_request = !d[4];
                end
                caio_pkg::PORT_LINK_CTL: begin
                    raw_next = d[6];
                end
                caio_pkg::PORT_RAW_WIRE: begin
                    raw_next              = d[6];
                    meta.wire_drive_valid = d[6];
                    meta.red_wire_out     = d[6] & d[0];
                    meta.white_wire_out   = d[6] & d[1];
                end
                caio_pkg::PORT_LINK_DATA: begin
                    meta.link_tx_valid = 1'b1;
                    meta.data_imm      = d;
                end
                caio_pkg::PORT_LCD_HI: begin
                    lcd_base_next = {d, lcd_base_reg[7:0]};
                end
                caio_pkg::PORT_LCD_LO: begin
                    lcd_base_next = {lcd_base_reg[15:8], d};
                end
                caio_pkg::PORT_TIMER: begin
                    reload_next = d;
                end
                caio_pkg::PORT_LCD_OFF: begin
                    lcd_off_next      = d[7];
                    meta.stop_request = d[7];
                    meta.screen_event = d[7] ? caio_pkg::SCR_OFF : caio_pkg::SCR_ON;
                end
                caio_pkg::PORT_CONTRAST: begin
                    contrast_next = {d[3:0], contrast_reg[0]};
                end
                default: begin
                end
            endcase
        end else begin
            unique case (caio_pkg::READ_MAP[item.address])
                caio_pkg::RD_STATUS: begin
                    meta.data_imm    = {status_bit7_reg, 1'b0, contrast_reg[0], 5'b0}
                                       | caio_pkg::STATUS_B2;
                    status_bit2_next = 1'b1;
                end
                caio_pkg::RD_MEMCTL:   meta.data_imm = {5'b0, protect_reg, 1'b0, ram_128k_reg};
                caio_pkg::RD_ID_EVEN:  meta.data_imm = caio_pkg::ID_EVEN;
                caio_pkg::RD_ID_ODD:   meta.data_imm = caio_pkg::ID_ODD;
                caio_pkg::RD_ID_21:    meta.data_imm = caio_pkg::ID_PORT21;
                caio_pkg::RD_LINK_STAT: begin
                    meta.data_imm = item.link_byte_available ? caio_pkg::LINK_AVAIL
                                                             : caio_pkg::LINK_IDLE;
                end
                caio_pkg::RD_RAW: begin
                    meta.sel_mem  = !raw_reg;
                    meta.data_imm = caio_pkg::RAW_BASE
                                    | {6'b0, item.white_wire_level, item.red_wire_level};
                end
                caio_pkg::RD_LINK_RX: begin
                    meta.link_rx_taken = item.link_byte_available;
                    meta.data_imm      = item.link_rx_byte;
                end
                caio_pkg::RD_TIMER:    meta.data_imm = item.timer_count;
                caio_pkg::RD_ONKEY: begin
                    meta.data_imm = caio_pkg::ONKEY_BASE | {6'b0, !item.on_key_pressed, 1'b0};
                end
                caio_pkg::RD_KEYS:     meta.data_imm = item.key_row_mask;
                caio_pkg::RD_MEM:      meta.sel_mem  = 1'b1;
                default:               meta.sel_mem  = 1'b1;
            endcase
        end

        meta.contrast_level   = contrast_next;
        meta.lcd_base_address = {lcd_base_next, 3'b000};
        meta.ram_window_256k  = window_next;
        meta.memory_protect   = protect_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contrast_reg    <= '0;
            status_bit7_reg <= 1'b1;
            status_bit2_reg <= 1'b1;
            ram_128k_reg    <= 1'b0;
            protect_reg     <= 1'b0;
            wrap_reg        <= 1'b0;
            window_reg      <= 1'b0;
            raw_reg         <= 1'b0;
            lcd_base_reg    <= '0;
            lcd_off_reg     <= 1'b0;
            reload_reg      <= '0;
        end else if (accept) begin
            contrast_reg    <= contrast_next;
            status_bit7_reg <= status_bit7_next;
            status_bit2_reg <= status_bit2_next;
            ram_128k_reg    <= ram_128k_next;
            protect_reg     <= protect_next;
            wrap_reg        <= wrap_next;
            window_reg      <= window_next;
            raw_reg         <= raw_next;
            lcd_base_reg    <= lcd_base_next;
            lcd_off_reg     <= lcd_off_next;
            reload_reg      <= reload_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/calculator_asic_io_ports.sv */
`default_nettype none
// path: input transaction, port byte memory read, output register, result
// throughput: one transaction per cycle while m_tready takes results, limited by the single port byte memory port
// a result waiting at the output does not stop the next transaction entering the memory stage if that stage is empty
// reset: aresetn synchronous, active low; control registers return to their reset values and
// the per-entry valid bits of the port byte memory clear at once, so no clearing pass is needed
module calculator_asic_io_ports #(
    parameter int PORT_COUNT = caio_pkg::PORT_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,      // model_is_92
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,       // command
    // address, write_data, link_rx_byte, link_byte_available, timer_count,
    // on_key_pressed, key_row_mask, red_wire_level, white_wire_level, zero fill
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_out, link_tx_valid, link_rx_taken, stop_request, contrast_level,
    // screen_event, wire_drive_valid, red_wire_out, white_wire_out,
    // lcd_base_address, ram_window_256k, memory_protect, zero fill
    output logic [47:0]      m_tdata
);

    localparam int AW = $clog2(PORT_COUNT);

    caio_pkg::caio_item_t item;
    caio_pkg::caio_meta_t meta, s1_meta_reg;
    logic                 accept, advance;
    logic                 s1_valid_reg;
    logic                 out_valid_reg;
    logic [47:0]          out_data_reg;
    logic [7:0]           mem_rdata;
    logic [7:0]           data_out;

    assign cfg_ready = 1'b1;

    assign item.command             = s_tuser;
    assign item.address             = s_tdata[4:0];
    assign item.write_data          = s_tdata[12:5];
    assign item.link_rx_byte        = s_tdata[20:13];
    assign item.link_byte_available = s_tdata[21];
    assign item.timer_count         = s_tdata[29:22];
    assign item.on_key_pressed      = s_tdata[30];
    assign item.key_row_mask        = s_tdata[38:31];
    assign item.red_wire_level      = s_tdata[39];
    assign item.white_wire_level    = s_tdata[40];

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    caio_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_bit (cfg_data),
        .accept  (accept),
        .item    (item),
        .meta    (meta)
    );

    // read data only moves on a new transaction, so it holds while stage one stalls
    caio_port_ram #(
        .PORT_COUNT (PORT_COUNT),
        .AW         (AW)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (accept),
        .we      (item.command),
        .addr    (AW'(item.address)),
        .wdata   (item.write_data),
        .rdata   (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_meta_reg <= meta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign data_out = s1_meta_reg.sel_mem ? mem_rdata : s1_meta_reg.data_imm;

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'b0,
                             s1_meta_reg.memory_protect,
                             s1_meta_reg.ram_window_256k,
                             s1_meta_reg.lcd_base_address,
                             s1_meta_reg.white_wire_out,
                             s1_meta_reg.red_wire_out,
                             s1_meta_reg.wire_drive_valid,
                             s1_meta_reg.screen_event,
                             s1_meta_reg.contrast_level,
                             s1_meta_reg.stop_request,
                             s1_meta_reg.link_rx_taken,
                             s1_meta_reg.link_tx_valid,
                             data_out};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
